// ===== src/spr_pkg.sv =====
// Shared types and constants for the stream pattern replace block.
// Used by spr_cell, spr_out_buf and stream_pattern_replace; no dependencies.
package spr_pkg;

    localparam int BYTE_W              = 8;
    localparam int CNT_W               = 4;
    localparam int CFG_W               = 64;
    localparam int CFG_IDX_W           = 2;
    localparam int DEF_MAX_PATTERN     = 8;
    localparam int DEF_MAX_REPLACEMENT = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } cfg_idx_t;

    // Broadcast to every window cell
    typedef struct packed {
        logic              step;
        logic              shift;
        logic [CNT_W-1:0]  fill;
        logic [CNT_W-1:0]  plen;
        logic [BYTE_W-1:0] text;
    } cell_ctl_t;

    // Burst handed to the output buffer
    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] cnt;
        logic             has;
        logic             last;
    } burst_t;

endpackage

// ===== src/stream_pattern_replace.sv =====
// Stream search and replace of a configured byte pattern, non-overlapping.
// Depends on spr_pkg, spr_cell and spr_out_buf.
//
// Usage: text bytes enter on the in channel (in_valid / in_stall) with
// end_of_text on the final byte; results leave on the out channel
// (out_valid / out_stall), one byte per cycle, last_of_text on the final
// result of a text and has_byte low on an empty end marker.
// Configuration is written through cfg_we / cfg_index / cfg_data while idle;
// writing pattern_length drops any pending bytes.
// Each item is taken by a row of window cells that compare in parallel;
// its results are registered and appear on the output in the next cycle.
// Throughput: one item per cycle while each item gives at most one result.
// An item giving more than one result (match burst or end-of-text flush)
// holds in_stall until the single output shift line sends its last result.
// A stalled receiver holds the output and, while any result waits, the
// input. Reset empties the window and output and clears the configuration
// and control registers to zero (pattern length zero: pass through).
module stream_pattern_replace
    import spr_pkg::*;
#(
    parameter int MAX_PATTERN     = DEF_MAX_PATTERN,
    parameter int MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    text_byte,
    input  logic                 end_of_text,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 has_byte,
    output logic                 last_of_text
);

    localparam int OBUF_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
    localparam logic [CNT_W-1:0] MAX_PAT_L = CNT_W'(MAX_PATTERN);
    localparam logic [CNT_W-1:0] MAX_REP_L = CNT_W'(MAX_REPLACEMENT);
    localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);

    logic [CFG_W-1:0]  pattern_bytes_reg;
    logic [CNT_W-1:0]  pattern_length_reg;
    logic [CFG_W-1:0]  replacement_bytes_reg;
    logic [CNT_W-1:0]  replacement_length_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;

    logic [CNT_W-1:0]  plen;
    logic [CNT_W-1:0]  rlen;
    logic [CNT_W-1:0]  fill_eff;
    logic              in_acc;
    logic              full;
    logic              hit;
    logic              sel_rep;
    logic              room;
    logic              obuf_busy;
    cell_ctl_t         ctl;
    burst_t            burst;

    logic [BYTE_W-1:0] app      [MAX_PATTERN];
    logic [BYTE_W-1:0] next_app [MAX_PATTERN];
    logic              match_c  [MAX_PATTERN+1];
    logic [BYTE_W-1:0] load_bytes [OBUF_DEPTH];

    assign plen     = (pattern_length_reg > MAX_PAT_L) ? MAX_PAT_L : pattern_length_reg;
    assign rlen     = (replacement_length_reg > MAX_REP_L) ? MAX_REP_L
                                                           : replacement_length_reg;
    assign fill_eff = (fill_reg >= plen) ? '0 : fill_reg;
    assign in_stall = ~room;
    assign in_acc   = in_valid & room;
    assign full     = (plen != '0) & (fill_eff == plen - ONE);
    assign hit      = full & match_c[MAX_PATTERN];
    assign sel_rep  = hit;

    assign ctl.step  = in_acc & (plen != '0);
    assign ctl.shift = full & ~match_c[MAX_PATTERN];
    assign ctl.fill  = fill_eff;
    assign ctl.plen  = plen;
    assign ctl.text  = text_byte;

    assign match_c[0] = 1'b1;

    generate
        for (genvar k = 0; k < MAX_PATTERN; k++)
        begin : g_cell
            if (k < MAX_PATTERN - 1)
            begin : g_mid
                assign next_app[k] = app[k+1];
            end
            else
            begin : g_end
                assign next_app[k] = '0;
            end

            spr_cell #(
                .IDX (k)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .pat_byte  (pattern_bytes_reg[BYTE_W*k +: BYTE_W]),
                .next_app  (next_app[k]),
                .match_in  (match_c[k]),
                .app       (app[k]),
                .match_out (match_c[k+1])
            );
        end

        for (genvar k = 0; k < OBUF_DEPTH; k++)
        begin : g_load
            logic [BYTE_W-1:0] rep_b;
            logic [BYTE_W-1:0] app_b;
            if (k < MAX_REPLACEMENT)
            begin : g_rep
                assign rep_b = replacement_bytes_reg[BYTE_W*k +: BYTE_W];
            end
            else
            begin : g_norep
                assign rep_b = '0;
            end
            if (k < MAX_PATTERN)
            begin : g_app
                assign app_b = app[k];
            end
            else
            begin : g_noapp
                assign app_b = '0;
            end
            // empty end marker carries a zero byte
            assign load_bytes[k] = !burst.has ? '0
                                 : (sel_rep ? rep_b : ((plen == '0) ? text_byte : app_b));
        end
    endgenerate

    // result burst for the accepted item
    always_comb
    begin
        burst.load = in_acc;
        burst.has  = 1'b1;
        burst.last = end_of_text;
        fill_next  = fill_eff;
        if (plen == '0)
        begin
            burst.cnt = ONE;
            fill_next = '0;
        end
        else if (hit)
        begin
            burst.cnt = rlen;
            fill_next = '0;
            if ((rlen == '0) && end_of_text)
            begin
                burst.cnt = ONE;
                burst.has = 1'b0;
            end
        end
        else if (full)
        begin
            burst.cnt = end_of_text ? plen : ONE;
        end
        else
        begin
            burst.cnt = end_of_text ? (fill_eff + ONE) : '0;
            fill_next = fill_eff + ONE;
        end
        if (end_of_text)
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= '0;
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
            fill_reg               <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PATTERN_BYTES:
                begin
                    pattern_bytes_reg <= cfg_data;
                end
                CFG_PATTERN_LENGTH:
                begin
                    pattern_length_reg <= cfg_data[CNT_W-1:0];
                    fill_reg           <= '0;
                end
                CFG_REPLACEMENT_BYTES:
                begin
                    replacement_bytes_reg <= cfg_data;
                end
                CFG_REPLACEMENT_LENGTH:
                begin
                    replacement_length_reg <= cfg_data[CNT_W-1:0];
                end
                default:
                begin
                    fill_reg <= fill_reg;
                end
            endcase
        end
        else if (in_acc)
        begin
            fill_reg <= fill_next;
        end
    end

    spr_out_buf #(
        .DEPTH (OBUF_DEPTH)
    ) u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .burst        (burst),
        .load_bytes   (load_bytes),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .has_byte     (has_byte),
        .last_of_text (last_of_text),
        .room         (room),
        .busy         (obuf_busy)
    );

    a_fill_below_plen: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) || (fill_reg < plen))
        else $error("window fill not below pattern length");

    a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && end_of_text |=> fill_reg == '0)
        else $error("window not empty after end of text");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> last_of_text)
        else $error("empty marker not on final result");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        obuf_busy |-> in_stall)
        else $error("item taken while a burst is pending");

endmodule

// ===== src/spr_cell.sv =====
// One window cell: holds a pending byte, compares it with its pattern byte
// and hands its byte to the left neighbour on a mismatch shift. Uses spr_pkg.
module spr_cell
    import spr_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [BYTE_W-1:0] pat_byte,
    input  logic [BYTE_W-1:0] next_app,
    input  logic              match_in,
    output logic [BYTE_W-1:0] app,
    output logic              match_out
);

    localparam logic [CNT_W-1:0] IDX_L = CNT_W'(IDX);

    logic [BYTE_W-1:0] win_reg;
    logic              active;

    // window contents with the new item appended at the fill position
    assign app       = (ctl.fill == IDX_L) ? ctl.text : win_reg;
    assign active    = IDX_L < ctl.plen;
    assign match_out = match_in & (~active | (app == pat_byte));

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            if (ctl.shift)
            begin
                win_reg <= next_app;
            end
            else if (ctl.fill == IDX_L)
            begin
                win_reg <= ctl.text;
            end
        end
    end

endmodule

// ===== src/spr_out_buf.sv =====
// Output shift line: holds the results of one item and presents them one
// per cycle on the output channel while out_stall is low. Uses spr_pkg.
module spr_out_buf
    import spr_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_PATTERN
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  burst_t            burst,
    input  logic [BYTE_W-1:0] load_bytes [DEPTH],
    input  logic              out_stall,
    output logic              out_valid,
    output logic [BYTE_W-1:0] out_byte,
    output logic              has_byte,
    output logic              last_of_text,
    output logic              room,
    output logic              busy
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ONE = CW'(1);

    logic [BYTE_W-1:0] slot_reg [DEPTH];
    logic [CW-1:0]     cnt_reg;
    logic              has_reg;
    logic              last_reg;
    logic              pop;

    assign out_valid    = cnt_reg != '0;
    assign pop          = out_valid & ~out_stall;
    assign out_byte     = slot_reg[0];
    assign has_byte     = has_reg;
    assign last_of_text = last_reg & (cnt_reg == ONE);
    assign room         = (cnt_reg == '0) | ((cnt_reg == ONE) & pop);
    assign busy         = cnt_reg > ONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            has_reg  <= 1'b0;
            last_reg <= 1'b0;
        end
        else if (burst.load)
        begin
            cnt_reg  <= CW'(burst.cnt);
            has_reg  <= burst.has;
            last_reg <= burst.last;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - ONE;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            if (burst.load)
            begin
                slot_reg[k] <= load_bytes[k];
            end
            else if (pop && (k < DEPTH - 1))
            begin
                slot_reg[k] <= slot_reg[(k + 1) % DEPTH];
            end
        end
    end

endmodule
